>>> src/pes_timestamp_rebaser_unit_defines.svh
// assertion macros shared by the pes timestamp rebaser checker
`ifndef PES_TIMESTAMP_REBASER_UNIT_DEFINES_SVH
`define PES_TIMESTAMP_REBASER_UNIT_DEFINES_SVH

// clocked assertion, idle while reset is held low
`define PESR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PESR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pesr_pkg.sv
// types, constants and stamp helpers for the pes timestamp rebaser
package pesr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STAMP_W    = 33;
    localparam int unsigned POS_W      = 9;
    localparam int unsigned HOLD_DEPTH = 10;
    localparam int unsigned IDX_W      = $clog2(HOLD_DEPTH);

    typedef logic [BYTE_W-1:0]                  t_byte;
    typedef logic [STAMP_W-1:0]                 t_stamp;
    typedef logic [POS_W-1:0]                   t_pos;
    typedef logic [IDX_W-1:0]                   t_idx;
    typedef logic [HOLD_DEPTH-1:0][BYTE_W-1:0]  t_hold_bytes;
    typedef logic [1:0]                         t_flags;

    localparam t_pos POS_FLAGS      = t_pos'(7);
    localparam t_pos POS_HOLD_FIRST = t_pos'(9);
    localparam t_pos POS_HOLD_LAST  = t_pos'(18);
    localparam t_pos POS_MAX        = t_pos'(511);

    localparam t_idx IDX_LAST = t_idx'(HOLD_DEPTH - 1);
    localparam t_idx IDX_DTS  = t_idx'(5);

    localparam t_byte PTS_FLAG_MASK  = 8'h80;
    localparam t_byte DTS_FLAG_MASK  = 8'h40;
    localparam t_byte PREFIX_PTS     = 8'h21;
    localparam t_byte PREFIX_PTS_DTS = 8'h31;
    localparam t_byte PREFIX_DTS     = 8'h11;

    // pull the 33 stamp bits out of five header bytes, markers dropped
    function automatic t_stamp decode_stamp(input t_byte b0, input t_byte b1,
                                            input t_byte b2, input t_byte b3,
                                            input t_byte b4);
        return {b0[3:1], b1, b2[7:1], b3, b4[7:1]};
    endfunction

    // subtract the start offset, clamp at zero
    function automatic t_stamp rebase(input t_stamp v, input t_stamp off);
        logic [STAMP_W:0] diff;
        diff = {1'b0, v} - {1'b0, off};
        return diff[STAMP_W] ? '0 : diff[STAMP_W-1:0];
    endfunction

    // lay a stamp back into five bytes with marker bits and prefix
    function automatic logic [4:0][BYTE_W-1:0] encode_stamp(input t_stamp v,
                                                            input t_byte prefix);
        logic [4:0][BYTE_W-1:0] b;
        b[0] = {4'b0000, v[32:30], 1'b0} + prefix;
        b[1] = v[29:22];
        b[2] = {v[21:15], 1'b1};
        b[3] = v[14:7];
        b[4] = {v[6:0], 1'b1};
        return b;
    endfunction

endpackage

>>> src/pesr_ifs.sv
// valid/ready channel interfaces for header bytes, result bytes and config

interface pesr_in_if;
    logic         valid;
    logic         ready;
    logic [7:0]   header_byte;
    logic         end_of_header;
    modport source (output valid, output header_byte, output end_of_header, input ready);
    modport sink   (input valid, input header_byte, input end_of_header, output ready);
endinterface

interface pesr_out_if;
    logic         valid;
    logic         ready;
    logic [7:0]   out_byte;
    logic         out_end;
    modport source (output valid, output out_byte, output out_end, input ready);
    modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

interface pesr_cfg_if;
    logic         valid;
    logic         ready;
    logic [32:0]  start_offset;
    modport source (output valid, output start_offset, input ready);
    modport sink   (input valid, input start_offset, output ready);
endinterface

>>> src/pesr_stamp_rewrite.sv
// decodes, rebases and re-encodes the pts and dts held in bytes 9 to 18
module pesr_stamp_rewrite (
    input  pesr_pkg::t_hold_bytes i_bytes,
    input  pesr_pkg::t_flags      i_flags,
    input  pesr_pkg::t_stamp      i_offset,
    output pesr_pkg::t_hold_bytes o_bytes
);
    import pesr_pkg::*;

    t_stamp                 w_pts;
    t_stamp                 w_dts;
    logic [4:0][BYTE_W-1:0] w_pts_enc;
    logic [4:0][BYTE_W-1:0] w_dts_enc;
    logic                   w_pts_nz;
    logic                   w_dts_nz;

    // decode only the stamps whose flag is set
    always_comb begin
        w_pts = i_flags[1] ? decode_stamp(i_bytes[0], i_bytes[1], i_bytes[2],
                                          i_bytes[3], i_bytes[4]) : '0;
        w_dts = i_flags[0] ? decode_stamp(i_bytes[5], i_bytes[6], i_bytes[7],
                                          i_bytes[8], i_bytes[9]) : '0;
        w_pts_nz = (w_pts != '0);
        w_dts_nz = (w_dts != '0);
    end

    // two parallel subtracts, then re-encode with marker bits
    always_comb begin
        w_pts_enc = encode_stamp(rebase(w_pts, i_offset),
                                 w_dts_nz ? PREFIX_PTS_DTS : PREFIX_PTS);
        w_dts_enc = encode_stamp(rebase(w_dts, i_offset), PREFIX_DTS);
    end

    // zero stamps stay as they were in the bytes
    always_comb begin
        o_bytes = i_bytes;
        if (w_pts_nz) begin
            for (int i = 0; i < 5; i++) begin
                o_bytes[i] = w_pts_enc[i];
            end
        end
        if (w_dts_nz) begin
            for (int i = 0; i < 5; i++) begin
                o_bytes[i + 5] = w_dts_enc[i];
            end
        end
    end

endmodule

>>> src/pes_timestamp_rebaser_unit.sv
// pes timestamp rebaser top level: pass-through, hold buffer and flush
// a passed-through byte goes from the input register to the output register
// held bytes 9 to 18 leave one per cycle unless the output stalls, after the last one is in
// throughput: 1 byte per cycle unless the output stalls; a byte that closes the hold
// window, or ends the header in it, stalls input until all held bytes (up to 10) drain
// reset: synchronous active low, clears position, flags, valids and start offset to 0
module pes_timestamp_rebaser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pesr_in_if.sink     i_hdr,
    pesr_out_if.source  o_res,
    pesr_cfg_if.sink    i_cfg
);
    import pesr_pkg::*;

    // input register
    logic        r_in_vld;
    t_byte       r_in_byte;
    logic        r_in_end;

    // header tracking state
    t_pos        r_pos;
    t_flags      r_flags;
    t_stamp      r_offset;
    t_hold_bytes r_held;

    // drain of the hold buffer
    logic        r_drain_act;
    t_idx        r_drain_idx;
    t_idx        r_drain_last;
    logic        r_drain_end;

    // output register
    logic        r_out_vld;
    t_byte       r_out_byte;
    logic        r_out_end;

    logic        w_out_free;
    logic        w_core_take;
    logic        w_drain_step;
    logic        w_hold;
    logic        w_hold_close;
    t_pos        w_pos_off;
    t_idx        w_hold_idx;
    t_hold_bytes w_cur_bytes;
    t_hold_bytes w_new_bytes;

    // handshake decisions
    always_comb begin
        w_out_free   = !r_out_vld || o_res.ready;
        w_drain_step = r_drain_act && w_out_free;
        w_core_take  = r_in_vld && !r_drain_act && w_out_free;
        w_hold       = (r_pos >= POS_HOLD_FIRST) && (r_pos <= POS_HOLD_LAST);
        w_hold_close = (r_pos == POS_HOLD_LAST);
        w_pos_off    = r_pos - POS_HOLD_FIRST;
        w_hold_idx   = w_pos_off[IDX_W-1:0];
    end

    assign i_hdr.ready = !r_in_vld || w_core_take;
    assign i_cfg.ready = 1'b1;

    // last held byte joins the buffer before the rewrite
    always_comb begin
        w_cur_bytes           = r_held;
        w_cur_bytes[IDX_LAST] = r_in_byte;
    end

    pesr_stamp_rewrite u_rewrite (
        .i_bytes  (w_cur_bytes),
        .i_flags  (r_flags),
        .i_offset (r_offset),
        .o_bytes  (w_new_bytes)
    );

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_hdr.ready) begin
            r_in_vld <= i_hdr.valid;
        end
        if (i_hdr.valid && i_hdr.ready) begin
            r_in_byte <= i_hdr.header_byte;
            r_in_end  <= i_hdr.end_of_header;
        end
    end

    // start offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg.valid) begin
            r_offset <= i_cfg.start_offset;
        end
    end

    // byte position and stamp flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flags <= '0;
        end else if (w_core_take) begin
            if (r_in_end) begin
                r_pos   <= '0;
                r_flags <= '0;
            end else begin
                if (r_pos == POS_FLAGS) begin
                    r_flags <= {(r_in_byte & PTS_FLAG_MASK) != '0,
                                (r_in_byte & DTS_FLAG_MASK) != '0};
                end
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + t_pos'(1);
                end
            end
        end
    end

    // hold buffer, rewritten in place when the window closes
    always_ff @(posedge i_clk) begin
        if (w_core_take && w_hold) begin
            if (w_hold_close) begin
                r_held <= w_new_bytes;
            end else begin
                r_held[w_hold_idx] <= r_in_byte;
            end
        end
    end

    // drain control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_act <= 1'b0;
        end else if (w_drain_step) begin
            if (r_drain_idx == r_drain_last) begin
                r_drain_act <= 1'b0;
            end
            r_drain_idx <= r_drain_idx + t_idx'(1);
        end else if (w_core_take && w_hold && (w_hold_close || r_in_end)) begin
            r_drain_act  <= 1'b1;
            r_drain_idx  <= '0;
            r_drain_last <= w_hold_close ? IDX_LAST : w_hold_idx;
            r_drain_end  <= r_in_end;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_drain_step) begin
            r_out_vld  <= 1'b1;
            r_out_byte <= r_held[r_drain_idx];
            r_out_end  <= (r_drain_idx == r_drain_last) && r_drain_end;
        end else if (w_core_take && !w_hold) begin
            r_out_vld  <= 1'b1;
            r_out_byte <= r_in_byte;
            r_out_end  <= r_in_end;
        end else if (w_out_free) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.out_byte = r_out_byte;
    assign o_res.out_end  = r_out_end;

endmodule

>>> src/pesr_checker.sv
// port-level checker for the pes timestamp rebaser, bound to the top level
`include "pes_timestamp_rebaser_unit_defines.svh"

module pesr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_vld,
    input logic       i_in_rdy,
    input logic       i_out_vld,
    input logic       i_out_rdy,
    input logic [7:0] i_out_byte,
    input logic       i_out_end
);
    logic [4:0] r_bal;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_in_vld && i_in_rdy;
    assign w_out_beat = i_out_vld && i_out_rdy;

    // beats accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal <= '0;
        end else begin
            r_bal <= r_bal + {4'b0000, w_in_beat} - {4'b0000, w_out_beat};
        end
    end

    `PESR_ASSERT(a_out_valid_holds, i_clk, i_rst_n, (i_out_vld && !i_out_rdy) |=> i_out_vld, "output valid dropped while stalled")
    `PESR_ASSERT(a_out_payload_holds, i_clk, i_rst_n, (i_out_vld && !i_out_rdy) |=> ($stable(i_out_byte) && $stable(i_out_end)), "output payload changed while stalled")
    `PESR_ASSERT(a_no_invented_beat, i_clk, i_rst_n, (r_bal == 5'd0) |-> !w_out_beat, "output beat with no input beat pending")
    `PESR_ASSERT(a_bounded_backlog, i_clk, i_rst_n, r_bal <= 5'd12, "more beats pending than the block can store")

endmodule

bind pes_timestamp_rebaser_unit pesr_checker u_pesr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_vld   (i_hdr.valid),
    .i_in_rdy   (i_hdr.ready),
    .i_out_vld  (o_res.valid),
    .i_out_rdy  (o_res.ready),
    .i_out_byte (o_res.out_byte),
    .i_out_end  (o_res.out_end)
);

>>> sim/tb.sv
// self-checking bench for the pes timestamp rebaser: directed and random headers, stamp predictor
module tb;
    import pesr_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BEATS   = 20;

    typedef struct packed {
        t_byte b;
        logic  e;
    } out_beat_t;

    typedef struct packed {
        logic      typed;
        out_beat_t want;
    } beat_note_t;

    typedef struct packed {
        t_byte hb;
        logic  last;
        logic  typed;
        t_byte want_b;
        logic  want_e;
    } dir_row_t;

    typedef enum logic {HDR_FULL, HDR_CUT} hdr_kind_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pesr_in_if  hdr_ch ();
    pesr_out_if res_ch ();
    pesr_cfg_if cfg_ch ();

    pes_timestamp_rebaser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // header model state
    t_stamp mdl_offset   = '0;
    t_pos   mdl_pos      = '0;
    t_flags mdl_flags    = '0;
    t_byte  mdl_held [HOLD_DEPTH];
    int     mdl_held_cnt = 0;

    // expected output beats and per-beat notes from the sender
    out_beat_t  beats_due[$];
    beat_note_t beat_notes[$];

    int err_count   = 0;
    int cycle_count = 0;
    int flag_turn   = 0;
    bit steady      = 1'b0;

    // directed headers: early end with both flags, one-byte headers, early end on first held byte
    dir_row_t directed [25] = '{
        '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
        '{8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
        '{8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
        '{8'h7F, 1'b0, 1'b1, 8'h7F, 1'b0},
        '{8'h55, 1'b0, 1'b1, 8'h55, 1'b0},
        '{8'hAA, 1'b0, 1'b1, 8'hAA, 1'b0},
        '{8'hC0, 1'b0, 1'b1, 8'hC0, 1'b0},
        '{8'h0A, 1'b0, 1'b1, 8'h0A, 1'b0},
        '{8'h31, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFE, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
        '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
        '{8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
        '{8'h33, 1'b0, 1'b1, 8'h33, 1'b0},
        '{8'h21, 1'b0, 1'b1, 8'h21, 1'b0},
        '{8'h9C, 1'b0, 1'b1, 8'h9C, 1'b0},
        '{8'h40, 1'b0, 1'b1, 8'h40, 1'b0},
        '{8'h05, 1'b0, 1'b1, 8'h05, 1'b0},
        '{8'h81, 1'b1, 1'b1, 8'h81, 1'b1}
    };

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    // 33 stamp bits from five held bytes, markers dropped
    function automatic t_stamp held_stamp(input int at);
        return {mdl_held[at][3:1], mdl_held[at+1], mdl_held[at+2][7:1],
                mdl_held[at+3], mdl_held[at+4][7:1]};
    endfunction

    // stamp minus start offset, floored at zero
    function automatic t_stamp shift_back(input t_stamp v);
        return (v < mdl_offset) ? t_stamp'(0) : t_stamp'(v - mdl_offset);
    endfunction

    // write a stamp back into the held bytes with markers set
    function automatic void restamp(input int at, input t_stamp v, input t_byte prefix);
        mdl_held[at]   = prefix + {4'b0000, v[32:30], 1'b0};
        mdl_held[at+1] = v[29:22];
        mdl_held[at+2] = {v[21:15], 1'b1};
        mdl_held[at+3] = v[14:7];
        mdl_held[at+4] = {v[6:0], 1'b1};
    endfunction

    // rebase pts and dts in place as the flags allow
    function automatic void rebase_held_stamps();
        t_stamp pts;
        t_stamp dts;
        pts = mdl_flags[1] ? held_stamp(0) : t_stamp'(0);
        dts = mdl_flags[0] ? held_stamp(IDX_DTS) : t_stamp'(0);
        if (pts != 0) begin
            restamp(0, shift_back(pts), (dts != 0) ? PREFIX_PTS_DTS : PREFIX_PTS);
        end
        if (dts != 0) begin
            restamp(IDX_DTS, shift_back(dts), PREFIX_DTS);
        end
    endfunction

    // emit all held bytes, end flag on the last one
    function automatic void release_held(input logic last, ref out_beat_t outs[$]);
        for (int i = 0; i < mdl_held_cnt; i++) begin
            outs.push_back(out_beat_t'{mdl_held[i], (i == mdl_held_cnt - 1) ? last : 1'b0});
        end
        mdl_held_cnt = 0;
    endfunction

    // output beats caused by one header byte
    function automatic void predict_header_beat(input t_byte hb, input logic last,
                                                ref out_beat_t outs[$]);
        t_pos pos;
        pos = mdl_pos;
        if (pos == POS_FLAGS) begin
            mdl_flags = {(hb & PTS_FLAG_MASK) != 0, (hb & DTS_FLAG_MASK) != 0};
        end
        if (pos >= POS_HOLD_FIRST && pos <= POS_HOLD_LAST) begin
            mdl_held[mdl_held_cnt] = hb;
            mdl_held_cnt++;
            if (pos == POS_HOLD_LAST) begin
                rebase_held_stamps();
                release_held(last, outs);
            end else if (last) begin
                release_held(1'b1, outs);
            end
        end else begin
            outs.push_back(out_beat_t'{hb, last});
        end
        if (last) begin
            mdl_pos      = '0;
            mdl_flags    = '0;
            mdl_held_cnt = 0;
        end else if (pos != POS_MAX) begin
            mdl_pos = pos + t_pos'(1);
        end
    endfunction

    // input and output beat monitor: predict on accept, compare on result
    always @(posedge i_clk) begin : beat_monitor
        out_beat_t  fresh[$];
        beat_note_t note;
        out_beat_t  want;
        if (i_rst_n && hdr_ch.valid && hdr_ch.ready) begin
            note = beat_notes.pop_front();
            fresh.delete();
            predict_header_beat(hdr_ch.header_byte, hdr_ch.end_of_header, fresh);
            if (note.typed) begin
                beats_due.push_back(note.want);
            end else begin
                foreach (fresh[i]) beats_due.push_back(fresh[i]);
            end
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (beats_due.size() == 0) begin
                err_count++;
                if (err_count < 40) begin
                    $display("%0t: unexpected out beat byte %h end %b",
                             $time, res_ch.out_byte, res_ch.out_end);
                end
            end else begin
                want = beats_due.pop_front();
                if (res_ch.out_byte !== want.b) begin
                    err_count++;
                    if (err_count < 40) begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, want.b, res_ch.out_byte);
                    end
                end
                if (res_ch.out_end !== want.e) begin
                    err_count++;
                    if (err_count < 40) begin
                        $display("%0t: out_end mismatch: expected %b, actual %b",
                                 $time, want.e, res_ch.out_end);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result sink with random back-pressure
    initial begin : res_sink
        int run;
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
            res_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // drive one header beat and wait for its accept
    task automatic send_beat(input t_byte hb, input logic last, input logic typed,
                             input t_byte wb, input logic we);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            hdr_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat_notes.push_back(beat_note_t'{typed, out_beat_t'{wb, we}});
        hdr_ch.valid         <= 1'b1;
        hdr_ch.header_byte   <= hb;
        hdr_ch.end_of_header <= last;
        @(posedge i_clk);
        while (!hdr_ch.ready) @(posedge i_clk);
    endtask

    // hold off input until every expected beat is out, then linger
    task automatic settle_results(input int extra);
        hdr_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // start offset register write
    task automatic load_offset(input t_stamp v);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.start_offset <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        mdl_offset = v;
    endtask

    // stamp values around the current offset and the range ends
    function automatic t_stamp pick_stamp();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return mdl_offset;
            2: return mdl_offset - 1'b1;
            3: return '1;
            4: return mdl_offset + t_stamp'($urandom_range(1, 255));
            default: return {1'($urandom_range(0, 1)), 32'($urandom)};
        endcase
    endfunction

    // lay a stamp into five bytes with random prefix nibble and marker bits
    function automatic void lay_stamp(ref t_byte hb[$], input int at, input t_stamp v);
        hb[at]   = {4'($urandom), v[32:30], 1'($urandom)};
        hb[at+1] = v[29:22];
        hb[at+2] = {v[21:15], 1'($urandom)};
        hb[at+3] = v[14:7];
        hb[at+4] = {v[6:0], 1'($urandom)};
    endfunction

    // build and send one header of the given kind
    task automatic send_header(input hdr_kind_t kind, output int len);
        t_byte     hb[$];
        logic [1:0] sel;
        case (kind)
            HDR_FULL: len = ($urandom_range(0, 3) == 0) ? 19 : $urandom_range(20, 27);
            default:  len = $urandom_range(1, 18);
        endcase
        for (int i = 0; i < len; i++) hb.push_back(t_byte'($urandom));
        if (kind == HDR_FULL) begin
            // cycle through the four flag combinations
            sel = 2'(flag_turn);
            flag_turn++;
            hb[POS_FLAGS] = (hb[POS_FLAGS] & 8'h3F) | (sel[1] ? PTS_FLAG_MASK : 8'h00)
                            | (sel[0] ? DTS_FLAG_MASK : 8'h00);
            if ($urandom_range(0, 4) != 0) begin
                lay_stamp(hb, POS_HOLD_FIRST, pick_stamp());
                lay_stamp(hb, POS_HOLD_FIRST + IDX_DTS, pick_stamp());
            end
        end
        for (int i = 0; i < len; i++) begin
            send_beat(hb[i], i == len - 1, 1'b0, 8'h00, 1'b0);
        end
    endtask

    // stimulus
    initial begin : stim
        int     len;
        int     phase_beats;
        t_stamp nv;
        i_rst_n              <= 1'b0;
        hdr_ch.valid         <= 1'b0;
        hdr_ch.header_byte   <= '0;
        hdr_ch.end_of_header <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.start_offset  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at the reset offset
        foreach (directed[i]) begin
            send_beat(directed[i].hb, directed[i].last, directed[i].typed,
                      directed[i].want_b, directed[i].want_e);
        end

        // random phases, one start offset each
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                settle_results(SETTLE_CYCLES);
                case (ph)
                    1:       nv = '1;
                    2:       nv = {1'($urandom_range(0, 1)), 32'($urandom)};
                    3:       nv = 33'd1;
                    default: nv = '0;
                endcase
                load_offset(nv);
            end
            steady = (ph == 2);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                send_header(($urandom_range(0, 3) == 0) ? HDR_CUT : HDR_FULL, len);
                phase_beats += len;
                if ($urandom_range(0, 5) == 0) begin
                    settle_results(0);
                end
            end
        end

        settle_results(SETTLE_CYCLES);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/pesr_pkg.sv
src/pesr_ifs.sv
src/pesr_stamp_rewrite.sv
src/pes_timestamp_rebaser_unit.sv
src/pesr_checker.sv
sim/tb.sv
